// ===== rtl/core/vblifo_pkg.sv =====
package vblifo_pkg;

    localparam int MEM_BYTES   = 4096;
    localparam int INDEX_BYTES = 8;
    localparam int MAX_BLOCK   = 64;
    localparam int IDX_DEPTH   = MEM_BYTES / INDEX_BYTES;

    localparam int DATA_AW = $clog2(MEM_BYTES);
    localparam int IDX_AW  = $clog2(IDX_DEPTH);
    localparam int FILL_W  = DATA_AW + 1;
    localparam int LEN_W   = 7;
    localparam int CAP_W   = 13;
    localparam int CNT_W   = 10;
    localparam int NEED_W  = FILL_W + 2;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_POP     = 2'd1,
        OP_REVERSE = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        K_PUSH_OK     = 3'd0,
        K_PUSH_REJ    = 3'd1,
        K_POP_BYTE    = 3'd2,
        K_POP_REFUSED = 3'd3,
        K_REVERSED    = 3'd4,
        K_CLEARED     = 3'd5
    } kind_t;

    typedef struct packed {
        op_t              op;
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] block_length;
        logic             last_byte;
        logic [CAP_W-1:0] max_size;
    } cmd_t;

    typedef struct packed {
        logic   valid;
        cmd_t   cmd;
    } cmd_req_t;

    typedef struct packed {
        logic [DATA_AW-1:0] offset;
        logic [LEN_W-1:0]   length;
    } idx_entry_t;

    localparam int IDX_W = $bits(idx_entry_t);

endpackage

// ===== rtl/core/vblifo_ram.sv =====
module vblifo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/vblifo_front.sv =====
module vblifo_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  vblifo_pkg::cmd_t     in_cmd,
    output vblifo_pkg::cmd_req_t req,
    input  logic                 cmd_done
);

    import vblifo_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign in_stall  = (count_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign pop       = cmd_done && (count_reg != 2'd0);
    assign req.valid = (count_reg != 2'd0);
    assign req.cmd   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("Request queue count out of range.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("Full queue has mismatched pointers.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("Queue with one request has equal pointers.");

endmodule

// ===== rtl/core/vblifo_back.sv =====
module vblifo_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  vblifo_pkg::cmd_req_t        req,
    output logic                        cmd_done,
    input  logic                        cfg_write,
    input  logic [vblifo_pkg::CAP_W-1:0] cfg_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [2:0]                  kind,
    output logic [7:0]                  out_byte,
    output logic                        last_result,
    output logic [6:0]                  popped_length,
    output logic [9:0]                  block_count,
    output logic [6:0]                  next_block_size
);

    import vblifo_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b0000000001,
        ST_POP_IDX  = 10'b0000000010,
        ST_POP_TOP  = 10'b0000000100,
        ST_POP_RD   = 10'b0000001000,
        ST_POP_EMIT = 10'b0000010000,
        ST_REV_RLO  = 10'b0000100000,
        ST_REV_RHI  = 10'b0001000000,
        ST_REV_WLO  = 10'b0010000000,
        ST_REV_WHI  = 10'b0100000000,
        ST_REV_DONE = 10'b1000000000
    } state_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_OPEN   = 3'b010,
        PH_FAILED = 3'b100
    } phase_t;

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next, phase_mid;
    logic [CAP_W-1:0]   cap_reg, cap_eff;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]   stored_reg, stored_next;
    logic [LEN_W-1:0]   top_len_reg, top_len_next;
    logic [LEN_W-1:0]   seen_reg, seen_next, seen_base, seen_mid;
    logic [DATA_AW-1:0] pop_off_reg, pop_off_next;
    logic [LEN_W-1:0]   pop_len_reg, pop_len_next;
    logic [LEN_W-1:0]   cnt_reg, cnt_next;
    logic               zero_reg, zero_next;
    logic [IDX_AW-1:0]  lo_reg, lo_next, hi_reg, hi_next;
    idx_entry_t         tmp_a_reg, tmp_a_next;

    logic               out_valid_reg;
    kind_t              kind_reg;
    logic [7:0]         byte_reg;
    logic               last_reg;
    logic [LEN_W-1:0]   plen_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [LEN_W-1:0]   nsize_reg;

    logic               slot_free;
    logic               emit_en;
    kind_t              e_kind;
    logic [7:0]         e_byte;
    logic               e_last;
    logic [LEN_W-1:0]   e_plen;

    logic               d_we, d_re;
    logic [DATA_AW-1:0] d_waddr, d_raddr;
    logic [7:0]         d_wdata, d_rdata;
    logic               i_we, i_re;
    logic [IDX_AW-1:0]  i_waddr, i_raddr;
    idx_entry_t         i_wdata, i_rdata;

    logic [LEN_W-1:0]   len;
    logic [NEED_W-1:0]  need;
    logic               space_ok;
    logic               len_bad;
    logic               push_ok;
    logic               pop_bad;
    logic [FILL_W-1:0]  waddr_full;
    logic [FILL_W-1:0]  raddr_full;
    logic [LEN_W-1:0]   cnt_inc;

    assign slot_free = !out_valid_reg || !out_stall;
    assign cap_eff   = (cap_reg > CAP_W'(MEM_BYTES)) ? CAP_W'(MEM_BYTES) : cap_reg;
    assign len       = req.cmd.block_length;
    assign need      = NEED_W'(fill_reg)
                     + NEED_W'((NEED_W'(stored_reg) + NEED_W'(1)) * NEED_W'(INDEX_BYTES))
                     + NEED_W'(len);
    assign space_ok  = (stored_reg < CNT_W'(IDX_DEPTH)) && (need <= NEED_W'(cap_eff));
    assign len_bad   = (len == '0) || (len > LEN_W'(MAX_BLOCK));
    assign pop_bad   = (i_rdata.length == '0) || (i_rdata.length > LEN_W'(MAX_BLOCK))
                     || (req.cmd.max_size < CAP_W'(i_rdata.length));
    assign raddr_full = FILL_W'(pop_off_reg) + FILL_W'(cnt_reg);
    assign cnt_inc    = cnt_reg + LEN_W'(1);

    always_comb
    begin
        case (phase_reg)
            PH_IDLE:
            begin
                seen_base = '0;
                phase_mid = (len_bad || !space_ok) ? PH_FAILED : PH_OPEN;
            end
            PH_OPEN:
            begin
                seen_base = seen_reg;
                phase_mid = (seen_reg >= len || len > LEN_W'(MAX_BLOCK) || !space_ok)
                          ? PH_FAILED : PH_OPEN;
            end
            default:
            begin
                seen_base = seen_reg;
                phase_mid = PH_FAILED;
            end
        endcase
        waddr_full = fill_reg + FILL_W'(seen_base);
        seen_mid   = (phase_mid == PH_OPEN) ? seen_base + LEN_W'(1) : seen_base;
        push_ok    = (phase_mid == PH_OPEN) && (seen_mid == len);
    end

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        seen_next    = seen_reg;
        fill_next    = fill_reg;
        stored_next  = stored_reg;
        top_len_next = top_len_reg;
        pop_off_next = pop_off_reg;
        pop_len_next = pop_len_reg;
        cnt_next     = cnt_reg;
        zero_next    = zero_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        tmp_a_next   = tmp_a_reg;
        cmd_done     = 1'b0;
        emit_en      = 1'b0;
        e_kind       = K_PUSH_OK;
        e_byte       = '0;
        e_last       = 1'b1;
        e_plen       = '0;
        d_we         = 1'b0;
        d_waddr      = waddr_full[DATA_AW-1:0];
        d_wdata      = req.cmd.data_byte;
        d_re         = 1'b0;
        d_raddr      = raddr_full[DATA_AW-1:0];
        i_we         = 1'b0;
        i_waddr      = stored_reg[IDX_AW-1:0];
        i_wdata      = '{offset: fill_reg[DATA_AW-1:0], length: len};
        i_re         = 1'b0;
        i_raddr      = lo_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.cmd.op)
                        OP_PUSH:
                        begin
                            if (!req.cmd.last_byte || slot_free)
                            begin
                                cmd_done = 1'b1;
                                d_we = (phase_mid == PH_OPEN)
                                    && (waddr_full < FILL_W'(MEM_BYTES));
                                if (req.cmd.last_byte)
                                begin
                                    phase_next = PH_IDLE;
                                    seen_next  = '0;
                                    emit_en    = 1'b1;
                                    e_kind     = push_ok ? K_PUSH_OK : K_PUSH_REJ;
                                    if (push_ok)
                                    begin
                                        i_we         = 1'b1;
                                        fill_next    = fill_reg + FILL_W'(len);
                                        stored_next  = stored_reg + CNT_W'(1);
                                        top_len_next = len;
                                    end
                                end
                                else
                                begin
                                    phase_next = phase_mid;
                                    seen_next  = seen_mid;
                                end
                            end
                        end
                        OP_POP:
                        begin
                            phase_next = PH_IDLE;
                            seen_next  = '0;
                            if (stored_reg == '0)
                            begin
                                if (slot_free)
                                begin
                                    cmd_done = 1'b1;
                                    emit_en  = 1'b1;
                                    e_kind   = K_POP_REFUSED;
                                end
                            end
                            else
                            begin
                                i_re       = 1'b1;
                                i_raddr    = IDX_AW'(stored_reg - CNT_W'(1));
                                state_next = ST_POP_IDX;
                            end
                        end
                        OP_REVERSE:
                        begin
                            phase_next = PH_IDLE;
                            seen_next  = '0;
                            lo_next    = '0;
                            hi_next    = IDX_AW'(stored_reg - CNT_W'(1));
                            state_next = (stored_reg > CNT_W'(1)) ? ST_REV_RLO : ST_REV_DONE;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                            seen_next  = '0;
                            if (slot_free)
                            begin
                                cmd_done     = 1'b1;
                                fill_next    = '0;
                                stored_next  = '0;
                                top_len_next = '0;
                                emit_en      = 1'b1;
                                e_kind       = K_CLEARED;
                            end
                        end
                    endcase
                end
            end
            ST_POP_IDX:
            begin
                if (pop_bad)
                begin
                    if (slot_free)
                    begin
                        cmd_done   = 1'b1;
                        emit_en    = 1'b1;
                        e_kind     = K_POP_REFUSED;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    pop_off_next = i_rdata.offset;
                    pop_len_next = i_rdata.length;
                    cnt_next     = '0;
                    stored_next  = stored_reg - CNT_W'(1);
                    if (stored_reg == CNT_W'(1))
                    begin
                        fill_next    = '0;
                        top_len_next = '0;
                    end
                    else if (FILL_W'(i_rdata.offset) + FILL_W'(i_rdata.length) == fill_reg)
                    begin
                        fill_next = fill_reg - FILL_W'(i_rdata.length);
                    end
                    i_re       = 1'b1;
                    i_raddr    = IDX_AW'(stored_reg - CNT_W'(2));
                    state_next = ST_POP_TOP;
                end
            end
            ST_POP_TOP:
            begin
                top_len_next = (stored_reg == '0) ? '0 : i_rdata.length;
                state_next   = ST_POP_RD;
            end
            ST_POP_RD:
            begin
                d_re       = 1'b1;
                zero_next  = (raddr_full >= FILL_W'(MEM_BYTES));
                state_next = ST_POP_EMIT;
            end
            ST_POP_EMIT:
            begin
                if (slot_free)
                begin
                    emit_en = 1'b1;
                    e_kind  = K_POP_BYTE;
                    e_byte  = zero_reg ? 8'd0 : d_rdata;
                    e_last  = (cnt_inc == pop_len_reg);
                    e_plen  = pop_len_reg;
                    cnt_next = cnt_inc;
                    if (cnt_inc == pop_len_reg)
                    begin
                        cmd_done   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_POP_RD;
                    end
                end
            end
            ST_REV_RLO:
            begin
                i_re       = 1'b1;
                i_raddr    = lo_reg;
                state_next = ST_REV_RHI;
            end
            ST_REV_RHI:
            begin
                tmp_a_next = i_rdata;
                if (lo_reg == '0)
                begin
                    top_len_next = i_rdata.length;
                end
                i_re       = 1'b1;
                i_raddr    = hi_reg;
                state_next = ST_REV_WLO;
            end
            ST_REV_WLO:
            begin
                i_we       = 1'b1;
                i_waddr    = lo_reg;
                i_wdata    = i_rdata;
                state_next = ST_REV_WHI;
            end
            ST_REV_WHI:
            begin
                i_we       = 1'b1;
                i_waddr    = hi_reg;
                i_wdata    = tmp_a_reg;
                lo_next    = lo_reg + IDX_AW'(1);
                hi_next    = hi_reg - IDX_AW'(1);
                state_next = (lo_reg + IDX_AW'(1) < hi_reg - IDX_AW'(1))
                           ? ST_REV_RLO : ST_REV_DONE;
            end
            ST_REV_DONE:
            begin
                if (slot_free)
                begin
                    cmd_done   = 1'b1;
                    emit_en    = 1'b1;
                    e_kind     = K_REVERSED;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    vblifo_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_data_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .re    (d_re),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    vblifo_ram #(
        .WIDTH (IDX_W),
        .DEPTH (IDX_DEPTH)
    ) u_index_ram (
        .clk   (clk),
        .we    (i_we),
        .waddr (i_waddr),
        .wdata (i_wdata),
        .re    (i_re),
        .raddr (i_raddr),
        .rdata (i_rdata)
    );

    always_ff @(posedge clk)
    begin
        pop_off_reg <= pop_off_next;
        pop_len_reg <= pop_len_next;
        cnt_reg     <= cnt_next;
        zero_reg    <= zero_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        tmp_a_reg   <= tmp_a_next;
        if (slot_free && emit_en)
        begin
            kind_reg  <= e_kind;
            byte_reg  <= e_byte;
            last_reg  <= e_last;
            plen_reg  <= e_plen;
            count_reg <= stored_next;
            nsize_reg <= top_len_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_IDLE;
            seen_reg      <= '0;
            cap_reg       <= CAP_W'(MEM_BYTES);
            fill_reg      <= '0;
            stored_reg    <= '0;
            top_len_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            seen_reg    <= seen_next;
            fill_reg    <= fill_next;
            stored_reg  <= stored_next;
            top_len_reg <= top_len_next;
            if (cfg_write)
            begin
                cap_reg <= cfg_data;
            end
            if (slot_free)
            begin
                out_valid_reg <= emit_en;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign kind            = kind_reg;
    assign out_byte        = byte_reg;
    assign last_result     = last_reg;
    assign popped_length   = plen_reg;
    assign block_count     = count_reg;
    assign next_block_size = nsize_reg;

    assert property (@(posedge clk) disable iff (!rst_n) stored_reg <= CNT_W'(IDX_DEPTH))
        else $error("Stored block count exceeds index depth.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (stored_reg == '0) |-> (fill_reg == '0 && top_len_reg == '0))
        else $error("Empty store has nonzero fill or top length.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP_EMIT) |-> (cnt_reg < pop_len_reg))
        else $error("Pop byte counter ran past block length.");

endmodule

// ===== rtl/core/variable_block_lifo_buffer_top.sv =====
// Last-in-first-out store of variable-length byte blocks.
// Requests enter on in_valid/in_stall with operation, data_byte, block_length,
// last_byte and max_size; a request is taken when in_valid is high and in_stall low.
// Results leave on out_valid/out_stall, one result per accepted edge.
// A push streams one byte per request at one per cycle while the back end is idle;
// only the closing byte gives a result, which waits for a free output register.
// A pop reads the top index entry and the one below it, then alternates reading a
// byte from the data memory and emitting it, paced by that registered read.
// Reverse swaps pairs of index entries through the index memory's read and write
// ports, then gives one result; clear gives one result at once.
// A two-entry request queue sits in front of the executing logic, so requests
// keep entering while a result waits to be taken.
// Reset empties the store and sets the capacity register to 4096 bytes; the
// memories are not cleared. While out_stall is high the result register holds
// and the back end waits; the queue then fills and raises in_stall.
// cfg_write sets the capacity from cfg_data; the user keeps it between requests.
module variable_block_lifo_buffer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [7:0]  data_byte,
    input  logic [6:0]  block_length,
    input  logic        last_byte,
    input  logic [12:0] max_size,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  out_byte,
    output logic        last_result,
    output logic [6:0]  popped_length,
    output logic [9:0]  block_count,
    output logic [6:0]  next_block_size,
    input  logic        cfg_write,
    input  logic [12:0] cfg_data
);

    import vblifo_pkg::*;

    cmd_t     in_cmd;
    cmd_req_t req;
    logic     cmd_done;

    assign in_cmd = '{op: op_t'(operation), data_byte: data_byte,
                      block_length: block_length, last_byte: last_byte,
                      max_size: max_size};

    vblifo_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_cmd   (in_cmd),
        .req      (req),
        .cmd_done (cmd_done)
    );

    vblifo_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req),
        .cmd_done        (cmd_done),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .out_byte        (out_byte),
        .last_result     (last_result),
        .popped_length   (popped_length),
        .block_count     (block_count),
        .next_block_size (next_block_size)
    );

endmodule

// ===== bench/variable_block_lifo_buffer_top_test.sv =====
module variable_block_lifo_buffer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import vblifo_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int LONG_HOLD_CYCLES = 400;

    typedef struct {
        op_t        op;
        logic [7:0] data_byte;
        logic [6:0] block_length;
        logic       last_byte;
        logic [12:0] max_size;
    } request_t;

    typedef struct {
        kind_t      kind;
        logic [7:0] out_byte;
        logic       last_result;
        logic [6:0] popped_length;
        logic [9:0] block_count;
        logic [6:0] next_block_size;
    } lifo_result_t;

    typedef enum int { PUSH_IDLE, PUSH_OPEN, PUSH_FAILED } push_state_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  operation;
    logic [7:0]  data_byte;
    logic [6:0]  block_length;
    logic        last_byte;
    logic [12:0] max_size;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic        last_result;
    logic [6:0]  popped_length;
    logic [9:0]  block_count;
    logic [6:0]  next_block_size;
    logic        cfg_write;
    logic [12:0] cfg_data;

    request_t     pending_requests[$];
    lifo_result_t expected_results[$];

    logic [7:0]  model_bytes[MEM_BYTES];
    logic [11:0] model_offsets[IDX_DEPTH];
    logic [6:0]  model_lengths[IDX_DEPTH];
    int          model_fill;
    int          model_blocks;
    push_state_t model_push;
    int          model_push_seen;
    int          model_capacity;

    int  sender_idle_pct;
    int  receiver_idle_pct;
    bit  long_hold_armed;
    bit  long_hold_done;
    int  long_hold_left;
    int  mismatches;
    int  results_checked;
    int  requests_sent;
    int  cycles;

    variable_block_lifo_buffer_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .data_byte       (data_byte),
        .block_length    (block_length),
        .last_byte       (last_byte),
        .max_size        (max_size),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .out_byte        (out_byte),
        .last_result     (last_result),
        .popped_length   (popped_length),
        .block_count     (block_count),
        .next_block_size (next_block_size),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int usable_capacity();
        return (model_capacity > MEM_BYTES) ? MEM_BYTES : model_capacity;
    endfunction

    function automatic bit room_for(int len);
        if (model_blocks >= IDX_DEPTH)
            return 1'b0;
        return (usable_capacity() - model_fill - (model_blocks + 1) * INDEX_BYTES) >= len;
    endfunction

    task automatic record_result(kind_t k, logic [7:0] b, logic lst, logic [6:0] plen);
        lifo_result_t r;
        r.kind = k;
        r.out_byte = b;
        r.last_result = lst;
        r.popped_length = plen;
        r.block_count = model_blocks[9:0];
        r.next_block_size = (model_blocks == 0) ? 7'd0 : model_lengths[model_blocks - 1];
        expected_results.push_back(r);
    endtask

    task automatic predict_request(request_t req);
        int len;
        int off;
        int i;
        logic [7:0] popped[$];
        logic [11:0] tmp_off;
        logic [6:0] tmp_len;
        bit ok;
        len = req.block_length;
        case (req.op)
            OP_PUSH:
            begin
                if (model_push == PUSH_IDLE)
                begin
                    model_push_seen = 0;
                    if (len == 0 || len > MAX_BLOCK || !room_for(len))
                        model_push = PUSH_FAILED;
                    else
                        model_push = PUSH_OPEN;
                end
                else if (model_push == PUSH_OPEN)
                begin
                    if (model_push_seen >= len || len > MAX_BLOCK || !room_for(len))
                        model_push = PUSH_FAILED;
                end
                if (model_push == PUSH_OPEN)
                begin
                    model_bytes[model_fill + model_push_seen] = req.data_byte;
                    model_push_seen++;
                end
                if (req.last_byte)
                begin
                    ok = (model_push == PUSH_OPEN) && (model_push_seen == len);
                    if (ok)
                    begin
                        model_offsets[model_blocks] = model_fill[11:0];
                        model_lengths[model_blocks] = len[6:0];
                        model_fill += len;
                        model_blocks++;
                    end
                    model_push = PUSH_IDLE;
                    model_push_seen = 0;
                    record_result(ok ? K_PUSH_OK : K_PUSH_REJ, 8'd0, 1'b1, 7'd0);
                end
            end
            OP_POP:
            begin
                model_push = PUSH_IDLE;
                model_push_seen = 0;
                if (model_blocks == 0 || req.max_size < model_lengths[model_blocks - 1])
                    record_result(K_POP_REFUSED, 8'd0, 1'b1, 7'd0);
                else
                begin
                    off = model_offsets[model_blocks - 1];
                    len = model_lengths[model_blocks - 1];
                    for (i = 0; i < len; i++)
                        popped.push_back(model_bytes[off + i]);
                    if (off + len == model_fill)
                        model_fill -= len;
                    model_blocks--;
                    if (model_blocks == 0)
                        model_fill = 0;
                    for (i = 0; i < len; i++)
                        record_result(K_POP_BYTE, popped[i], i == len - 1, len[6:0]);
                end
            end
            OP_REVERSE:
            begin
                model_push = PUSH_IDLE;
                model_push_seen = 0;
                for (i = 0; i < model_blocks / 2; i++)
                begin
                    tmp_off = model_offsets[i];
                    tmp_len = model_lengths[i];
                    model_offsets[i] = model_offsets[model_blocks - 1 - i];
                    model_lengths[i] = model_lengths[model_blocks - 1 - i];
                    model_offsets[model_blocks - 1 - i] = tmp_off;
                    model_lengths[model_blocks - 1 - i] = tmp_len;
                end
                record_result(K_REVERSED, 8'd0, 1'b1, 7'd0);
            end
            default:
            begin
                model_push = PUSH_IDLE;
                model_push_seen = 0;
                model_fill = 0;
                model_blocks = 0;
                record_result(K_CLEARED, 8'd0, 1'b1, 7'd0);
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            operation <= OP_CLEAR;
            data_byte <= 8'd0;
            block_length <= 7'd0;
            last_byte <= 1'b0;
            max_size <= 13'd0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                in_valid <= 1'b1;
                operation <= pending_requests[0].op;
                data_byte <= pending_requests[0].data_byte;
                block_length <= pending_requests[0].block_length;
                last_byte <= pending_requests[0].last_byte;
                max_size <= pending_requests[0].max_size;
                void'(pending_requests.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            long_hold_left <= 0;
            long_hold_done <= 1'b0;
        end
        else if (long_hold_armed && !long_hold_done)
        begin
            out_stall <= 1'b1;
            long_hold_left <= LONG_HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end
        else if (long_hold_left > 0)
        begin
            out_stall <= 1'b1;
            long_hold_left <= long_hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        lifo_result_t exp_r;
        request_t req;
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d byte=%02h", kind, out_byte);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (kind !== exp_r.kind || out_byte !== exp_r.out_byte
                    || last_result !== exp_r.last_result
                    || popped_length !== exp_r.popped_length
                    || block_count !== exp_r.block_count
                    || next_block_size !== exp_r.next_block_size)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected kind=%0d byte=%02h last=%0d plen=%0d cnt=%0d next=%0d, got kind=%0d byte=%02h last=%0d plen=%0d cnt=%0d next=%0d",
                                 exp_r.kind, exp_r.out_byte, exp_r.last_result,
                                 exp_r.popped_length, exp_r.block_count, exp_r.next_block_size,
                                 kind, out_byte, last_result, popped_length, block_count,
                                 next_block_size);
                end
            end
        end
        if (rst_n && in_valid && !in_stall)
        begin
            req.op = op_t'(operation);
            req.data_byte = data_byte;
            req.block_length = block_length;
            req.last_byte = last_byte;
            req.max_size = max_size;
            requests_sent++;
            predict_request(req);
        end
    end

    task automatic queue_request(op_t op, logic [7:0] b, logic [6:0] len, logic lst,
                                 logic [12:0] msz);
        request_t req;
        req.op = op;
        req.data_byte = b;
        req.block_length = len;
        req.last_byte = lst;
        req.max_size = msz;
        pending_requests.push_back(req);
    endtask

    task automatic queue_push(int len_field, int nbytes, bit close);
        int i;
        for (i = 0; i < nbytes; i++)
            queue_request(OP_PUSH, $urandom_range(255), len_field[6:0],
                          close && (i == nbytes - 1), $urandom_range(8191));
    endtask

    task automatic queue_other(op_t op, int msz);
        queue_request(op, $urandom_range(255), $urandom_range(127), $urandom_range(1), msz[12:0]);
    endtask

    task automatic settle();
        while (pending_requests.size() > 0 || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(int value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= value[12:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        model_capacity = value;
    endtask

    task automatic queue_random(int count);
        int start;
        int pick;
        int len;
        start = pending_requests.size();
        while (pending_requests.size() - start < count)
        begin
            pick = $urandom_range(99);
            len = ($urandom_range(19) == 0) ? MAX_BLOCK : $urandom_range(1, 12);
            if (pick < 55)
                queue_push(len, len, 1'b1);
            else if (pick < 75)
                queue_other(OP_POP, ($urandom_range(3) == 0) ? $urandom_range(8191)
                                                              : $urandom_range(64, 8191));
            else if (pick < 80)
                queue_other(OP_REVERSE, $urandom_range(8191));
            else if (pick < 83)
                queue_other(OP_CLEAR, $urandom_range(8191));
            else if (pick < 88)
                queue_push($urandom_range(127), $urandom_range(1, 6), 1'b1);
            else if (pick < 93)
                queue_push(len, len + ($urandom_range(1) ? 1 : -1) + 0, 1'b1);
            else
            begin
                queue_push(len, $urandom_range(1, len), 1'b0);
                queue_other(OP_POP, 8191);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = 13'd0;
        sender_idle_pct = 33;
        receiver_idle_pct = 62;
        long_hold_armed = 1'b0;
        mismatches = 0;
        results_checked = 0;
        requests_sent = 0;
        cycles = 0;
        model_fill = 0;
        model_blocks = 0;
        model_push = PUSH_IDLE;
        model_push_seen = 0;
        model_capacity = 4096;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_other(OP_POP, 8191);
        queue_request(OP_PUSH, 8'h00, 7'd1, 1'b1, 13'd0);
        queue_request(OP_PUSH, 8'hFF, 7'd2, 1'b0, 13'd0);
        queue_request(OP_PUSH, 8'hA5, 7'd2, 1'b1, 13'd0);
        queue_request(OP_PUSH, 8'h5A, 7'd0, 1'b1, 13'd0);
        queue_request(OP_PUSH, 8'h11, 7'd127, 1'b1, 13'd0);
        queue_push(3, 2, 1'b1);
        queue_push(2, 3, 1'b1);
        queue_push(4, 2, 1'b0);
        queue_other(OP_REVERSE, 0);
        queue_other(OP_POP, 0);
        queue_other(OP_POP, 8191);
        queue_push(MAX_BLOCK, MAX_BLOCK, 1'b1);
        queue_other(OP_POP, 63);
        queue_other(OP_POP, 64);
        queue_other(OP_CLEAR, 0);
        queue_other(OP_POP, 8191);
        settle();

        write_capacity(0);
        queue_push(1, 1, 1'b1);
        settle();
        write_capacity(8191);
        queue_push(5, 5, 1'b1);
        queue_push(7, 7, 1'b1);
        settle();

        queue_random(90);
        settle();

        sender_idle_pct = 62;
        receiver_idle_pct = 33;
        write_capacity(200);
        queue_random(80);
        settle();

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        write_capacity(4096);
        long_hold_armed = 1'b1;
        queue_random(80);
        settle();

        $display("Sent %0d requests and checked %0d results over capacities 0 to 8191,",
                 requests_sent, results_checked);
        $display("including a long output hold and %0d mismatches.", mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
